/* design/qwsr_pkg.sv */
// types, codes and constants shared by the queue with search and remove
package qwsr_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int VALUE_W = 32;
  localparam int ENTRY_COUNT_W = 7;

  typedef enum logic [1:0] {
    CMD_APPEND     = 2'd0,
    CMD_REMOVE     = 2'd1,
    CMD_LIST_FRONT = 2'd2,
    CMD_LIST_REAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_code_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0]         item_value;
    status_code_t               status;
    logic [ENTRY_COUNT_W-1:0]   entry_count;
    logic                       last;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_APPEND,
    S_EMPTY,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT,
    S_NOT_FOUND,
    S_REM_DONE,
    S_LIST_RD,
    S_LIST_OUT
  } state_t;

  typedef enum logic [1:0] {
    RD_OFF0,
    RD_OFF1,
    RD_OFF2
  } rd_off_t;

  typedef enum logic {
    WR_APPEND,
    WR_SHIFT
  } wr_sel_t;

  typedef enum logic [2:0] {
    RES_VALUE,
    RES_LIST,
    RES_FULL,
    RES_NOT_FOUND,
    RES_EMPTY
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     pos_inc;
    rd_off_t  rd_off;
    logic     rd_map;
    logic     wr_en;
    wr_sel_t  wr_sel;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     emit;
    res_sel_t res_sel;
    logic     last;
  } ctrl_t;

  typedef struct packed {
    logic count_zero;
    logic full;
    logic match;
    logic pos_last;
    logic pos_pen;
    logic out_free;
  } dp_stat_t;

endpackage

/* design/queue_with_search_remove_core.sv */
// top level of the bounded queue with append, remove by value and listing
//
// One word is taken at a time; in_stall stays high until every result word
// of the current command has been loaded into the output register. All
// timing is set by the single read port of the entry memory, one entry per
// cycle. Append: accept, then result. Remove, found or not: accept, read,
// a compare per entry up to and including the match (every entry if none),
// a move per entry behind it, then result. List: accept, read, then one
// result word per cycle while out_stall does not hold the output register.
// An empty or full result needs only accept and result. Any out_stall
// holds a result step. No clearing pass is needed after reset.
module queue_with_search_remove_core
  import qwsr_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
)
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  ctrl_t    ctrl;
  dp_stat_t stat;

  qwsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (in_word.cmd),
    .stat     (stat),
    .in_stall (in_stall),
    .ctrl     (ctrl)
  );

  qwsr_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .ctrl      (ctrl),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

/* design/qwsr_ctrl.sv */
// command sequencer for the queue with search and remove
module qwsr_ctrl
  import qwsr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  cmd_t     in_cmd,
  input  dp_stat_t stat,
  output logic     in_stall,
  output ctrl_t    ctrl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_cmd)
            CMD_APPEND: state_next = S_APPEND;
            CMD_REMOVE: state_next = stat.count_zero ? S_EMPTY : S_SRCH_RD;
            CMD_LIST_FRONT, CMD_LIST_REAR: begin
              state_next = stat.count_zero ? S_EMPTY : S_LIST_RD;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_APPEND, S_EMPTY, S_NOT_FOUND, S_REM_DONE: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_SRCH_RD: state_next = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (stat.match) begin
          state_next = stat.pos_last ? S_REM_DONE : S_SHIFT;
        end else if (stat.pos_last) begin
          state_next = S_NOT_FOUND;
        end
      end
      S_SHIFT: begin
        if (stat.pos_pen) begin
          state_next = S_REM_DONE;
        end
      end
      S_LIST_RD: state_next = S_LIST_OUT;
      S_LIST_OUT: begin
        if (stat.out_free && stat.pos_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    ctrl.rd_off = RD_OFF0;
    ctrl.wr_sel = WR_APPEND;
    ctrl.res_sel = RES_VALUE;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        ctrl.load = in_valid;
      end
      S_APPEND: begin
        if (stat.out_free) begin
          ctrl.emit = 1'b1;
          ctrl.last = 1'b1;
          if (stat.full) begin
            ctrl.res_sel = RES_FULL;
          end else begin
            ctrl.res_sel = RES_VALUE;
            ctrl.wr_en = 1'b1;
            ctrl.wr_sel = WR_APPEND;
            ctrl.cnt_inc = 1'b1;
          end
        end
      end
      S_EMPTY: begin
        ctrl.emit = stat.out_free;
        ctrl.last = 1'b1;
        ctrl.res_sel = RES_EMPTY;
      end
      S_NOT_FOUND: begin
        ctrl.emit = stat.out_free;
        ctrl.last = 1'b1;
        ctrl.res_sel = RES_NOT_FOUND;
      end
      S_REM_DONE: begin
        ctrl.emit = stat.out_free;
        ctrl.last = 1'b1;
        ctrl.res_sel = RES_VALUE;
        ctrl.cnt_dec = stat.out_free;
      end
      S_SRCH_RD: begin
        ctrl.rd_off = RD_OFF0;
      end
      S_SRCH_CMP: begin
        ctrl.rd_off = RD_OFF1;
        ctrl.pos_inc = !stat.match && !stat.pos_last;
      end
      S_SHIFT: begin
        ctrl.rd_off = RD_OFF2;
        ctrl.wr_en = 1'b1;
        ctrl.wr_sel = WR_SHIFT;
        ctrl.pos_inc = 1'b1;
      end
      S_LIST_RD: begin
        ctrl.rd_off = RD_OFF0;
        ctrl.rd_map = 1'b1;
      end
      S_LIST_OUT: begin
        ctrl.rd_map = 1'b1;
        if (stat.out_free) begin
          ctrl.emit = 1'b1;
          ctrl.res_sel = RES_LIST;
          ctrl.last = stat.pos_last;
          ctrl.rd_off = RD_OFF1;
          ctrl.pos_inc = !stat.pos_last;
        end else begin
          ctrl.rd_off = RD_OFF0;
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

/* design/qwsr_dp.sv */
// entry memory, count, search position and output register
module qwsr_dp
  import qwsr_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
)
(
  input  logic      clk,
  input  logic      rst,
  input  in_word_t  in_word,
  input  ctrl_t     ctrl,
  input  logic      out_stall,
  output dp_stat_t  stat,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = CW + 1;

  logic signed [VALUE_W-1:0] mem [DEPTH];
  logic signed [VALUE_W-1:0] rd_data;
  logic signed [VALUE_W-1:0] value_r;
  cmd_t                      cmd_r;
  logic [CW-1:0]             count;
  logic [CW-1:0]             count_next;
  logic [AW-1:0]             pos;

  logic [PW-1:0]             p_ext;
  logic [PW-1:0]             rev_ext;
  logic [PW-1:0]             addr_full;
  logic [AW-1:0]             rd_addr;
  logic [AW-1:0]             wr_addr;
  logic signed [VALUE_W-1:0] wr_data;

  always_comb begin
    case (ctrl.rd_off)
      RD_OFF1: p_ext = PW'(pos) + PW'(1);
      RD_OFF2: p_ext = PW'(pos) + PW'(2);
      default: p_ext = PW'(pos);
    endcase
    rev_ext = PW'(count) - PW'(1) - p_ext;
    addr_full = (ctrl.rd_map && cmd_r == CMD_LIST_REAR) ? rev_ext : p_ext;
    rd_addr = addr_full[AW-1:0];
  end

  always_comb begin
    if (ctrl.wr_sel == WR_SHIFT) begin
      wr_addr = pos;
      wr_data = rd_data;
    end else begin
      wr_addr = AW'(count);
      wr_data = value_r;
    end
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    count_next = count;
    if (ctrl.cnt_inc) begin
      count_next = count + CW'(1);
    end else if (ctrl.cnt_dec) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r <= in_word.cmd;
      value_r <= in_word.value;
      pos <= '0;
    end else if (ctrl.pos_inc) begin
      pos <= pos + AW'(1);
    end
  end

  always_comb begin
    stat.count_zero = (count == '0);
    stat.full = (count == CW'(DEPTH));
    stat.match = (rd_data == value_r);
    stat.pos_last = (PW'(pos) + PW'(1) == PW'(count));
    stat.pos_pen = (PW'(pos) + PW'(2) == PW'(count));
    stat.out_free = !out_valid || !out_stall;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_word.entry_count <= ENTRY_COUNT_W'(count_next);
      out_word.last <= ctrl.last;
      case (ctrl.res_sel)
        RES_VALUE: begin
          out_word.item_value <= value_r;
          out_word.status <= ST_OK;
        end
        RES_LIST: begin
          out_word.item_value <= rd_data;
          out_word.status <= ST_OK;
        end
        RES_FULL: begin
          out_word.item_value <= '0;
          out_word.status <= ST_FULL;
        end
        RES_NOT_FOUND: begin
          out_word.item_value <= '0;
          out_word.status <= ST_NOT_FOUND;
        end
        default: begin
          out_word.item_value <= '0;
          out_word.status <= ST_EMPTY;
        end
      endcase
    end
  end

endmodule

/* design/qwsr_chk.sv */
// port checker for the queue with search and remove, with its bind
module qwsr_chk
  import qwsr_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
)
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // a taken command leaves in_stall high in the cycle after it
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a command");

  // error results are single, final and zero
  a_err_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.status != ST_OK |->
      out_word.last && out_word.item_value == '0)
    else $error("error result not final or not zero");

  // full only reported at capacity, count never above capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      out_word.entry_count <= ENTRY_COUNT_W'(DEPTH) &&
      (out_word.status != ST_FULL ||
       out_word.entry_count == ENTRY_COUNT_W'(DEPTH)))
    else $error("entry count out of range");

endmodule

bind queue_with_search_remove_core qwsr_chk #(.DEPTH(DEPTH)) u_qwsr_chk (.*);
